FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file tupf_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TUPF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define TUPF_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: src/tupf_pkg.sv
// ----------------------------------------------------------------------------
// tupf_pkg
// Types, register codes and saturation helpers of the thermal updraft block.
// ----------------------------------------------------------------------------
package tupf_pkg;

    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd6;

    // register reset values (raw bits)
    localparam logic [30:0] RST_RADIUS    = 31'd65536;
    localparam logic [30:0] RST_HEIGHT    = 31'd393216;
    localparam logic [30:0] RST_STRENGTH  = 31'd458752;
    localparam logic [30:0] RST_TIME_STEP = 31'd1092;

    // y / 5 == (y * H3_RECIP) >> 34 for any 32-bit y
    localparam logic [31:0] H3_RECIP = 32'hCCCCCCCD;

    localparam logic [30:0] U31_MAX = 31'h7FFFFFFF;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        inverse_mass;
    } t_item;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
    } t_result;

    // geometry carried along the square root pipeline
    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic [30:0]        z;
    } t_geo_sb;

    // velocity side of an item
    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic               under;
        logic [30:0]        k;
    } t_kin_sb;

    // control carried along the divider pipeline
    typedef struct packed {
        logic    vert;
        logic    len_zero;
        logic    att_zero;
        t_kin_sb kin;
    } t_div_sb;

    function automatic logic signed [31:0] sat_s33(input logic signed [32:0] v);
        logic signed [31:0] res;
        if (v[32] == v[31]) begin
            res = v[31:0];
        end else begin
            res = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] sat_s65(input logic signed [64:0] v);
        logic signed [31:0] res;
        if ((&v[64:31]) || !(|v[64:31])) begin
            res = v[31:0];
        end else begin
            res = v[64] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        return res;
    endfunction

endpackage

FILE: src/thermal_updraft_particle_force.sv
// From start to o_strobe: stages 1..3, square roots, select, dividers, 5..11.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the 32-stage square root and the FRAC_BITS + 1 stage
// dividers, one result bit per stage.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults; the result receiver cannot stall.
// ----------------------------------------------------------------------------
// thermal_updraft_particle_force
// Velocity update of one particle under a thermal updraft, fully pipelined.
// ----------------------------------------------------------------------------
module thermal_updraft_particle_force
    import tupf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    output logic                 o_strobe,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int FB   = FRAC_BITS;
    localparam int U_W  = FB + 2;
    localparam int P_W  = U_W + 32;
    localparam int G_W  = 32 + FB + 2;
    localparam logic [P_W-1:0] P_RND = {{(P_W-FB){1'b0}}, {FB{1'b1}}};
    localparam logic [G_W-1:0] G_RND = {{(G_W-FB){1'b0}}, {FB{1'b1}}};
    localparam logic [63:0]    H_RND = {{(64-FB){1'b0}}, {FB{1'b1}}};
    localparam logic [FB:0]    ONE_A = {1'b1, {FB{1'b0}}};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [30:0]        r_radius;
    logic [30:0]        r_height;
    logic [30:0]        r_strength;
    logic signed [31:0] r_origin_x;
    logic signed [31:0] r_origin_y;
    logic signed [31:0] r_origin_z;
    logic [30:0]        r_time_step;
    logic [63:0]        r_h3_prod;
    logic [32:0]        h3_x;
    logic [30:0]        h3;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // write at most one register per accepted config beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= RST_RADIUS;
            r_height    <= RST_HEIGHT;
            r_strength  <= RST_STRENGTH;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_origin_z  <= '0;
            r_time_step <= RST_TIME_STEP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RADIUS:    r_radius    <= i_cfg_data[30:0];
                CFG_HEIGHT:    r_height    <= i_cfg_data[30:0];
                CFG_STRENGTH:  r_strength  <= i_cfg_data[30:0];
                CFG_ORIGIN_X:  r_origin_x  <= i_cfg_data;
                CFG_ORIGIN_Y:  r_origin_y  <= i_cfg_data;
                CFG_ORIGIN_Z:  r_origin_z  <= i_cfg_data;
                CFG_TIME_STEP: r_time_step <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // 0.3 of the height: (3h >> 1) / 5 through a reciprocal multiply
    assign h3_x = {2'b00, r_height} + {1'b0, r_height, 1'b0};

    always_ff @(posedge i_clk) begin
        r_h3_prod <= 64'(h3_x[32:1]) * 64'(H3_RECIP);
    end

    assign h3 = {1'b0, r_h3_prod[63:34]};

    // ------------------------------------------------------------------
    // stage 1: offsets from the origin and the k product
    // ------------------------------------------------------------------
    logic               r1_vld;
    logic signed [31:0] r1_d [3];
    logic [30:0]        r1_z;
    logic               r1_under;
    logic signed [31:0] r1_vel [3];
    logic [61:0]        r1_kp;
    logic signed [32:0] dx_w, dy_w, dz_w;
    logic signed [31:0] dz_sat;

    assign dx_w = $signed({i_item.pos_x[31], i_item.pos_x})
                - $signed({r_origin_x[31], r_origin_x});
    assign dy_w = $signed({i_item.pos_y[31], i_item.pos_y})
                - $signed({r_origin_y[31], r_origin_y});
    assign dz_w = $signed({i_item.pos_z[31], i_item.pos_z})
                - $signed({r_origin_z[31], r_origin_z});
    assign dz_sat = sat_s33(dz_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_d[0]   <= sat_s33(dx_w);
        r1_d[1]   <= sat_s33(dy_w);
        r1_d[2]   <= dz_sat;
        r1_under  <= dz_w[32];
        r1_z      <= dz_w[32] ? '0 : dz_sat[30:0];
        r1_vel[0] <= i_item.vel_x;
        r1_vel[1] <= i_item.vel_y;
        r1_vel[2] <= i_item.vel_z;
        r1_kp     <= 62'(i_item.inverse_mass) * 62'(r_time_step);
    end

    // ------------------------------------------------------------------
    // stage 2: squares and saturated k
    // ------------------------------------------------------------------
    logic               r2_vld;
    logic [62:0]        r2_sq [3];
    logic signed [31:0] r2_d [3];
    logic [30:0]        r2_z;
    logic               r2_under;
    logic signed [31:0] r2_vel [3];
    logic [30:0]        r2_k;
    logic signed [63:0] sq_w [3];
    logic [61:0]        kq_w;

    for (genvar i = 0; i < 3; i++) begin : g_sq
        assign sq_w[i] = 64'(r1_d[i]) * 64'(r1_d[i]);
    end

    assign kq_w = r1_kp >> FB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r2_sq[i]  <= sq_w[i][62:0];
            r2_d[i]   <= r1_d[i];
            r2_vel[i] <= r1_vel[i];
        end
        r2_z     <= r1_z;
        r2_under <= r1_under;
        r2_k     <= (|kq_w[61:31]) ? U31_MAX : kq_w[30:0];
    end

    // ------------------------------------------------------------------
    // stage 3: squared lengths
    // ------------------------------------------------------------------
    logic        r3_vld;
    logic [63:0] r3_sxy;
    logic [63:0] r3_s3;
    t_geo_sb     r3_geo;
    t_kin_sb     r3_kin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_sxy       <= 64'(r2_sq[0]) + 64'(r2_sq[1]);
        r3_s3        <= 64'(r2_sq[0]) + 64'(r2_sq[1]) + 64'(r2_sq[2]);
        r3_geo.dx    <= r2_d[0];
        r3_geo.dy    <= r2_d[1];
        r3_geo.dz    <= r2_d[2];
        r3_geo.z     <= r2_z;
        r3_kin.vx    <= r2_vel[0];
        r3_kin.vy    <= r2_vel[1];
        r3_kin.vz    <= r2_vel[2];
        r3_kin.under <= r2_under;
        r3_kin.k     <= r2_k;
    end

    // ------------------------------------------------------------------
    // square roots
    // ------------------------------------------------------------------
    logic        sq_vld;
    logic [31:0] lxy;
    logic [31:0] l3;
    t_geo_sb     sq_geo;
    t_kin_sb     sq_kin;

    tupf_isqrt #(.SB_W($bits(t_geo_sb))) u_sqrt_xy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_vld),
        .i_rad   (r3_sxy),
        .i_sb    (r3_geo),
        .o_valid (sq_vld),
        .o_root  (lxy),
        .o_sb    (sq_geo)
    );

    tupf_isqrt #(.SB_W($bits(t_kin_sb))) u_sqrt_3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_vld),
        .i_rad   (r3_s3),
        .i_sb    (r3_kin),
        .o_valid (),
        .o_root  (l3),
        .o_sb    (sq_kin)
    );

    // ------------------------------------------------------------------
    // select stage: inside or outside, divider operands
    // ------------------------------------------------------------------
    logic        r4_vld;
    logic [31:0] r4_num [3];
    logic        r4_neg [3];
    logic [31:0] r4_den;
    logic [31:0] r4_fnum;
    logic [31:0] r4_fden;
    t_div_sb     r4_sb;
    logic        in_col;
    logic [31:0] den_w;
    logic [30:0] lim_w;
    logic        att_zero_w;
    logic        len_zero_w;
    logic signed [31:0] dsel [3];

    assign in_col     = lxy < {1'b0, r_radius};
    assign den_w      = in_col ? l3 : lxy;
    assign len_zero_w = den_w == '0;
    assign lim_w      = in_col ? r_height : h3;
    assign att_zero_w = (lim_w == '0) || (sq_geo.z >= lim_w);
    assign dsel[0]    = sq_geo.dx;
    assign dsel[1]    = sq_geo.dy;
    assign dsel[2]    = in_col ? sq_geo.dz : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r4_num[i] <= len_zero_w ? '0 :
                         (dsel[i][31] ? 32'(-dsel[i]) : 32'(dsel[i]));
            // outside the column the force points back toward the axis
            r4_neg[i] <= in_col ? dsel[i][31] : !dsel[i][31];
        end
        r4_den         <= den_w;
        r4_fnum        <= att_zero_w ? '0 : {1'b0, sq_geo.z};
        r4_fden        <= {1'b0, lim_w};
        r4_sb.vert     <= in_col && (sq_geo.z < h3);
        r4_sb.len_zero <= len_zero_w;
        r4_sb.att_zero <= att_zero_w;
        r4_sb.kin      <= sq_kin;
    end

    // ------------------------------------------------------------------
    // unit vector and fade dividers
    // ------------------------------------------------------------------
    logic          dv_vld;
    logic [FB:0]   uq [3];
    logic          uneg [3];
    logic [FB:0]   fq;
    t_div_sb       dv_sb;

    for (genvar i = 0; i < 3; i++) begin : g_udiv
        tupf_div #(.FRAC_BITS(FB), .SB_W(1)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r4_vld),
            .i_num   (r4_num[i]),
            .i_den   (r4_den),
            .i_sb    (r4_neg[i]),
            .o_valid (),
            .o_quo   (uq[i]),
            .o_sb    (uneg[i])
        );
    end

    tupf_div #(.FRAC_BITS(FB), .SB_W($bits(t_div_sb))) u_fade_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_vld),
        .i_num   (r4_fnum),
        .i_den   (r4_fden),
        .i_sb    (r4_sb),
        .o_valid (dv_vld),
        .o_quo   (fq),
        .o_sb    (dv_sb)
    );

    // ------------------------------------------------------------------
    // stage 5: signed unit components and fade factor
    // ------------------------------------------------------------------
    logic                  r5_vld;
    logic signed [U_W-1:0] r5_u [3];
    logic [FB:0]           r5_att;
    t_kin_sb               r5_kin;
    logic signed [U_W-1:0] u_w [3];

    for (genvar i = 0; i < 3; i++) begin : g_unit
        logic signed [U_W-1:0] mag;
        assign mag = $signed({1'b0, uq[i]});
        assign u_w[i] = dv_sb.len_zero ? '0 : (uneg[i] ? -mag : mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_sb.vert) begin
            // low in the column: straight up at full strength
            r5_u[0] <= '0;
            r5_u[1] <= '0;
            r5_u[2] <= $signed({1'b0, ONE_A});
        end else begin
            for (int i = 0; i < 3; i++) begin
                r5_u[i] <= u_w[i];
            end
        end
        r5_att <= dv_sb.att_zero ? '0 : ONE_A - fq;
        r5_kin <= dv_sb.kin;
    end

    // ------------------------------------------------------------------
    // stages 6..11: scale by strength, fade, k, then add to velocity
    // ------------------------------------------------------------------
    logic                  r6_vld, r7_vld, r8_vld, r9_vld, r10_vld;
    logic signed [P_W-1:0] r6_p [3];
    logic signed [31:0]    r7_r [3];
    logic signed [G_W-1:0] r8_g [3];
    logic signed [31:0]    r9_f [3];
    logic signed [63:0]    r10_h [3];
    logic [FB:0]           r6_att, r7_att;
    t_kin_sb               r6_kin, r7_kin, r8_kin, r9_kin, r10_kin;
    logic signed [P_W-1:0] p_adj [3];
    logic signed [G_W-1:0] g_adj [3];
    logic signed [63:0]    h_adj [3];
    logic signed [63:0]    h_q [3];
    logic signed [64:0]    v_sum [3];
    logic signed [31:0]    v_sat [3];
    logic signed [31:0]    vel_w [3];
    logic                  r_out_vld;
    t_result               r_out;

    assign vel_w[0] = r10_kin.vx;
    assign vel_w[1] = r10_kin.vy;
    assign vel_w[2] = r10_kin.vz;

    for (genvar i = 0; i < 3; i++) begin : g_scale
        // divide by ONE, truncating toward zero
        assign p_adj[i] = r6_p[i] + (r6_p[i][P_W-1] ? $signed(P_RND) : '0);
        assign g_adj[i] = r8_g[i] + (r8_g[i][G_W-1] ? $signed(G_RND) : '0);
        assign h_adj[i] = r10_h[i] + (r10_h[i][63] ? $signed(H_RND) : '0);
        assign h_q[i]   = h_adj[i] >>> FB;
        assign v_sum[i] = 65'(vel_w[i]) + 65'(h_q[i]);
        assign v_sat[i] = sat_s65(v_sum[i]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r9_vld    <= 1'b0;
            r10_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            r8_vld    <= r7_vld;
            r9_vld    <= r8_vld;
            r10_vld   <= r9_vld;
            r_out_vld <= r10_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r6_p[i]  <= P_W'(r5_u[i]) * P_W'($signed({1'b0, r_strength}));
            r7_r[i]  <= 32'(p_adj[i] >>> FB);
            r8_g[i]  <= G_W'(r7_r[i]) * G_W'($signed({1'b0, r7_att}));
            r9_f[i]  <= 32'(g_adj[i] >>> FB);
            r10_h[i] <= 64'(r9_f[i]) * 64'($signed({1'b0, r9_kin.k}));
        end
        r6_att  <= r5_att;
        r7_att  <= r6_att;
        r6_kin  <= r5_kin;
        r7_kin  <= r6_kin;
        r8_kin  <= r7_kin;
        r9_kin  <= r8_kin;
        r10_kin <= r9_kin;

        // saturate and clamp underground fall
        r_out.new_vel_x <= v_sat[0];
        r_out.new_vel_y <= v_sat[1];
        r_out.new_vel_z <= (r10_kin.under && v_sat[2][31]) ? '0 : v_sat[2];
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

endmodule

FILE: src/tupf_isqrt.sv
// ----------------------------------------------------------------------------
// tupf_isqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module tupf_isqrt #(
    parameter int SB_W = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [63:0]     i_rad,
    input  logic [SB_W-1:0] i_sb,
    output logic            o_valid,
    output logic [31:0]     o_root,
    output logic [SB_W-1:0] o_sb
);

    localparam int NS    = 32;
    localparam int REM_W = 33;

    logic            r_vld  [0:NS-1];
    logic [63:0]     r_rad  [0:NS-1];
    logic [REM_W-1:0] r_rem [0:NS-1];
    logic [31:0]     r_root [0:NS-1];
    logic [SB_W-1:0] r_sb   [0:NS-1];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic            a_vld;
        logic [63:0]     a_rad;
        logic [REM_W-1:0] a_rem;
        logic [31:0]     a_root;
        logic [SB_W-1:0] a_sb;
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] diff;
        logic            ge;

        if (j == 0) begin : g_first
            assign a_vld  = i_valid;
            assign a_rad  = i_rad;
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_sb   = i_sb;
        end else begin : g_next
            assign a_vld  = r_vld[j-1];
            assign a_rad  = r_rad[j-1];
            assign a_rem  = r_rem[j-1];
            assign a_root = r_root[j-1];
            assign a_sb   = r_sb[j-1];
        end

        // bring down the next two radicand bits and try the next root bit
        assign cur   = {a_rem, a_rad[63:62]};
        assign trial = {1'b0, a_root, 2'b01};
        assign ge    = cur >= trial;
        assign diff  = cur - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[j]  <= {a_rad[61:0], 2'b00};
            r_rem[j]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
            r_root[j] <= {a_root[30:0], ge};
            r_sb[j]   <= a_sb;
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_sb    = r_sb[NS-1];

endmodule

FILE: src/tupf_div.sv
// ----------------------------------------------------------------------------
// tupf_div
// Pipelined fraction divider: floor(num * 2^FRAC_BITS / den) for num <= den,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module tupf_div #(
    parameter int FRAC_BITS = 16,
    parameter int SB_W      = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [31:0]        i_num,
    input  logic [31:0]        i_den,
    input  logic [SB_W-1:0]    i_sb,
    output logic               o_valid,
    output logic [FRAC_BITS:0] o_quo,
    output logic [SB_W-1:0]    o_sb
);

    localparam int NS = FRAC_BITS + 1;

    logic               r_vld [0:NS-1];
    logic [32:0]        r_rem [0:NS-1];
    logic [31:0]        r_den [0:NS-1];
    logic [FRAC_BITS:0] r_quo [0:NS-1];
    logic [SB_W-1:0]    r_sb  [0:NS-1];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic               a_vld;
        logic [32:0]        a_rem;
        logic [31:0]        a_den;
        logic [FRAC_BITS:0] a_quo;
        logic [SB_W-1:0]    a_sb;
        logic [32:0]        diff;
        logic               ge;

        if (j == 0) begin : g_first
            assign a_vld = i_valid;
            assign a_rem = {1'b0, i_num};
            assign a_den = i_den;
            assign a_quo = '0;
            assign a_sb  = i_sb;
        end else begin : g_next
            assign a_vld = r_vld[j-1];
            assign a_rem = r_rem[j-1];
            assign a_den = r_den[j-1];
            assign a_quo = r_quo[j-1];
            assign a_sb  = r_sb[j-1];
        end

        // subtract when it fits, then shift the remainder up
        assign ge   = a_rem >= {1'b0, a_den};
        assign diff = a_rem - {1'b0, a_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j] <= ge ? {diff[31:0], 1'b0} : {a_rem[31:0], 1'b0};
            r_den[j] <= a_den;
            r_quo[j] <= {a_quo[FRAC_BITS-1:0], ge};
            r_sb[j]  <= a_sb;
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_quo   = r_quo[NS-1];
    assign o_sb    = r_sb[NS-1];

endmodule

FILE: src/tupf_checker.sv
// ----------------------------------------------------------------------------
// tupf_checker
// Port-level checks of the updraft pipeline timing, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tupf_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe
);

    localparam int LAT = FRAC_BITS + 44;

    // every result traces back to an item taken with start high and busy low
    `TUPF_ASSERT(a_strobe_src, i_clk, i_rst_n, o_strobe |-> $past(start && !busy, LAT))

    // reset empties the pipeline
    `TUPF_ASSERT_NR(a_rst_flush, i_clk, !i_rst_n |=> !o_strobe)

    // no result leaves if reset was active when its item would have been taken
    `TUPF_ASSERT(a_rst_window, i_clk, i_rst_n, o_strobe |-> $past(i_rst_n, LAT))

endmodule

bind thermal_updraft_particle_force tupf_checker #(.FRAC_BITS(FRAC_BITS)) u_tupf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe)
);
